// File: rtl/core/nrpf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrpf_pkg
// Shared widths, command and selector codes, register indexes, FSM state and
// the control structs of the NAT record prefix and port filter.
// ----------------------------------------------------------------------------
package nrpf_pkg;

	localparam int ADDR_W     = 32;
	localparam int PORT_W     = 16;
	localparam int PROTO_W    = 8;
	localparam int EVT_W      = 8;
	localparam int CMD_W      = 2;
	localparam int SEL_W      = 3;
	localparam int LEN_W      = 6;
	localparam int NUM_PFX    = 3;
	localparam int NUM_PORT   = 3;
	localparam int NUM_LISTS  = NUM_PFX + NUM_PORT;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	localparam logic [SEL_W-1:0] SEL_SRC_PFX  = 3'd0;
	localparam logic [SEL_W-1:0] SEL_NAT_PFX  = 3'd1;
	localparam logic [SEL_W-1:0] SEL_DST_PFX  = 3'd2;
	localparam logic [SEL_W-1:0] SEL_SRC_PORT = 3'd3;
	localparam logic [SEL_W-1:0] SEL_NAT_PORT = 3'd4;
	localparam logic [SEL_W-1:0] SEL_DST_PORT = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_PROTO_EN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROTO_VAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EVENT_EN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EVENT_VAL = 2'd3;

	localparam logic [LEN_W-1:0] LEN_HOST = 6'd32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               proto_en;
		logic [PROTO_W-1:0] proto_val;
		logic               event_en;
		logic [EVT_W-1:0]   event_val;
	} cfg_t;

	typedef struct packed {
		logic [NUM_LISTS-1:0] en;
		logic [ADDR_W-1:0]    net;
		logic [ADDR_W-1:0]    mask;
		logic [PORT_W-1:0]    port;
	} rule_wr_t;

	typedef struct packed {
		logic [NUM_PFX-1:0][ADDR_W-1:0]  net;
		logic [NUM_PFX-1:0][ADDR_W-1:0]  mask;
		logic [NUM_PORT-1:0][PORT_W-1:0] port;
	} rule_rd_t;

	// Length zero gives an empty mask, anything from 32 up a host mask.
	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
		logic [ADDR_W-1:0] m;
		if (len == '0) begin
			m = '0;
		end else if (len >= LEN_HOST) begin
			m = '1;
		end else begin
			m = ~({ADDR_W{1'b1}} >> len);
		end
		return m;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/nrpf_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrpf_in_if
// Input channel: records, rule loads and clears, valid/ready handshake.
// ----------------------------------------------------------------------------
interface nrpf_in_if;
	logic                         valid;
	logic                         ready;
	logic [nrpf_pkg::CMD_W-1:0]   cmd;
	logic [nrpf_pkg::ADDR_W-1:0]  src_addr;
	logic [nrpf_pkg::ADDR_W-1:0]  nat_addr;
	logic [nrpf_pkg::ADDR_W-1:0]  dst_addr;
	logic [nrpf_pkg::PORT_W-1:0]  src_port;
	logic [nrpf_pkg::PORT_W-1:0]  nat_port;
	logic [nrpf_pkg::PORT_W-1:0]  dst_port;
	logic [nrpf_pkg::PROTO_W-1:0] protocol;
	logic [nrpf_pkg::EVT_W-1:0]   event_type;
	logic [nrpf_pkg::SEL_W-1:0]   list_select;
	logic [nrpf_pkg::ADDR_W-1:0]  entry_value;
	logic [nrpf_pkg::LEN_W-1:0]   entry_prefix_len;

	modport source (
		output valid, cmd, src_addr, nat_addr, dst_addr, src_port, nat_port, dst_port,
		output protocol, event_type, list_select, entry_value, entry_prefix_len,
		input  ready
	);
	modport sink (
		input  valid, cmd, src_addr, nat_addr, dst_addr, src_port, nat_port, dst_port,
		input  protocol, event_type, list_select, entry_value, entry_prefix_len,
		output ready
	);
endinterface
`default_nettype wire

// File: rtl/core/nrpf_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrpf_out_if
// Output channel: one match verdict per record, valid/ready handshake.
// ----------------------------------------------------------------------------
interface nrpf_out_if;
	logic valid;
	logic ready;
	logic matched;

	modport source (output valid, matched, input ready);
	modport sink (input valid, matched, output ready);
endinterface
`default_nettype wire

// File: rtl/core/nrpf_rule_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrpf_rule_mem
// Six rule tables, one write port and one registered read port shared by all.
// ----------------------------------------------------------------------------
module nrpf_rule_mem #(
	parameter int DEPTH = 32,
	parameter int IDX_W = 5
) (
	input  wire logic               clk,
	input  wire nrpf_pkg::rule_wr_t wr,
	input  wire logic [IDX_W-1:0]   wr_idx,
	input  wire logic [IDX_W-1:0]   rd_addr,
	output nrpf_pkg::rule_rd_t      rd
);
	import nrpf_pkg::*;

	logic [ADDR_W-1:0] net_mem  [NUM_PFX][DEPTH];
	logic [ADDR_W-1:0] mask_mem [NUM_PFX][DEPTH];
	logic [PORT_W-1:0] port_mem [NUM_PORT][DEPTH];

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_PFX; k++) begin
			if (wr.en[k]) begin
				net_mem[k][wr_idx]  <= wr.net;
				mask_mem[k][wr_idx] <= wr.mask;
			end
			rd.net[k]  <= net_mem[k][rd_addr];
			rd.mask[k] <= mask_mem[k][rd_addr];
		end
		for (int k = 0; k < NUM_PORT; k++) begin
			if (wr.en[NUM_PFX+k]) begin
				port_mem[k][wr_idx] <= wr.port;
			end
			rd.port[k] <= port_mem[k][rd_addr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/nrpf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrpf_ctrl
// List counts, load path, entry scan sequencer and verdict register.
// ----------------------------------------------------------------------------
module nrpf_ctrl #(
	parameter int DEPTH = 32,
	parameter int IDX_W = 5,
	parameter int CNT_W = 6
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire nrpf_pkg::cfg_t     cfg,
	nrpf_in_if.sink                 in_ch,
	nrpf_out_if.source              out_ch,
	output nrpf_pkg::rule_wr_t      wr,
	output logic [IDX_W-1:0]        wr_idx,
	output logic [IDX_W-1:0]        rd_addr,
	input  wire nrpf_pkg::rule_rd_t rd
);
	import nrpf_pkg::*;

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     cnt_q [NUM_LISTS];
	logic [CNT_W-1:0]     max_q, issue_q, rd_idx_s1;
	logic                 rd_valid_s1;
	logic [ADDR_W-1:0]    rec_addr_q [NUM_PFX];
	logic [PORT_W-1:0]    rec_port_q [NUM_PORT];
	logic [PROTO_W-1:0]   proto_q;
	logic [EVT_W-1:0]     event_q;
	logic [NUM_LISTS-1:0] hit_q, hit_now;
	logic                 out_valid_q, matched_q;

	logic                 in_fire, out_free, issuing, last_rd, sel_ok, load_ok;
	logic                 is_record, is_load, is_clear, cfg_ok;
	logic [CNT_W-1:0]     max_cnt, cnt_sel;
	logic [ADDR_W-1:0]    ld_mask;

	assign in_fire   = in_ch.valid && in_ch.ready;
	assign out_free  = !out_valid_q || out_ch.ready;
	assign is_record = in_ch.cmd == CMD_RECORD;
	assign is_load   = in_ch.cmd == CMD_LOAD;
	assign is_clear  = in_ch.cmd == CMD_CLEAR;
	assign issuing   = (state_q == ST_SCAN) && (issue_q < max_q);
	assign last_rd   = rd_valid_s1 && (rd_idx_s1 == max_q - CNT_W'(1));
	assign rd_addr   = issue_q[IDX_W-1:0];

	always_comb begin
		max_cnt = '0;
		for (int k = 0; k < NUM_LISTS; k++) begin
			if (cnt_q[k] > max_cnt) begin
				max_cnt = cnt_q[k];
			end
		end
	end

	// Load path: append at the current fill of the chosen list.
	assign sel_ok  = in_ch.list_select < SEL_W'(NUM_LISTS);
	assign cnt_sel = sel_ok ? cnt_q[in_ch.list_select] : '0;
	assign load_ok = in_fire && is_load && sel_ok && (cnt_sel < CNT_W'(DEPTH));
	assign ld_mask = prefix_mask(in_ch.entry_prefix_len);

	always_comb begin
		wr.en = '0;
		if (load_ok) begin
			wr.en[in_ch.list_select] = 1'b1;
		end
		wr.mask = ld_mask;
		wr.net  = in_ch.entry_value & ld_mask;
		wr.port = in_ch.entry_value[PORT_W-1:0];
	end
	assign wr_idx = cnt_sel[IDX_W-1:0];

	// Entries at or past a list's fill do not count for it.
	always_comb begin
		for (int k = 0; k < NUM_PFX; k++) begin
			hit_now[k] = ((rec_addr_q[k] & rd.mask[k]) == rd.net[k]) &&
				(rd_idx_s1 < cnt_q[k]);
		end
		for (int k = 0; k < NUM_PORT; k++) begin
			hit_now[NUM_PFX+k] = (rec_port_q[k] == rd.port[k]) &&
				(rd_idx_s1 < cnt_q[NUM_PFX+k]);
		end
	end

	assign cfg_ok = (!cfg.proto_en || (cfg.proto_val == proto_q)) &&
		(!cfg.event_en || (cfg.event_val == event_q));

	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_fire && is_record) begin
					state_d = (max_cnt == '0) ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_rd) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_LISTS; k++) begin
				cnt_q[k] <= '0;
			end
		end else if (in_fire && is_clear) begin
			for (int k = 0; k < NUM_LISTS; k++) begin
				cnt_q[k] <= '0;
			end
		end else if (load_ok) begin
			cnt_q[in_ch.list_select] <= cnt_sel + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q     <= '0;
			max_q       <= '0;
			rd_valid_s1 <= 1'b0;
			rd_idx_s1   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= issuing;
			rd_idx_s1   <= issue_q;
			if (in_fire && is_record) begin
				issue_q <= '0;
				max_q   <= max_cnt;
			end else if (issuing) begin
				issue_q <= issue_q + CNT_W'(1);
			end
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Record fields and running hits hold for the whole scan.
	always_ff @(posedge clk) begin
		if (in_fire && is_record) begin
			rec_addr_q[0] <= in_ch.src_addr;
			rec_addr_q[1] <= in_ch.nat_addr;
			rec_addr_q[2] <= in_ch.dst_addr;
			rec_port_q[0] <= in_ch.src_port;
			rec_port_q[1] <= in_ch.nat_port;
			rec_port_q[2] <= in_ch.dst_port;
			proto_q       <= in_ch.protocol;
			event_q       <= in_ch.event_type;
			for (int k = 0; k < NUM_LISTS; k++) begin
				hit_q[k] <= cnt_q[k] == '0;
			end
		end else if ((state_q == ST_SCAN) && rd_valid_s1) begin
			hit_q <= hit_q | hit_now;
		end
		if ((state_q == ST_DONE) && out_free) begin
			matched_q <= (&hit_q) && cfg_ok;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.matched = matched_q;

	a_rd_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (state_q == ST_SCAN))
		else $error("read data returned outside a scan");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (issue_q <= max_q))
		else $error("scan issued past the longest list");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && out_free) |=> (out_valid_q && (state_q == ST_IDLE)))
		else $error("verdict not posted on scan completion");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		last_rd |=> (state_q == ST_DONE))
		else $error("scan did not close on its last entry");

endmodule
`default_nettype wire

// File: rtl/core/nat_record_prefix_port_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nat_record_prefix_port_filter
// NAT log record filter: three address prefix lists, three port lists and
// optional protocol and event type checks.
// ----------------------------------------------------------------------------
// Load and clear words give no result.
// A record is scanned over every index below the entry count of its longest list
//   and holds the input until its verdict is posted; when all lists are empty the
//   scan is skipped. The single read port scans one index per cycle.
// The verdict register frees the input while a result waits to be taken.
// Reset clears list counts and configuration; table contents stay undefined.
module nat_record_prefix_port_filter #(
	parameter int LIST_DEPTH = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [nrpf_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [nrpf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	nrpf_in_if.sink                              in_ch,
	nrpf_out_if.source                           out_ch
);
	import nrpf_pkg::*;

	localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W = $clog2(LIST_DEPTH + 1);

	cfg_t             cfg_q;
	rule_wr_t         wr;
	rule_rd_t         rd;
	logic [IDX_W-1:0] wr_idx, rd_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_PROTO_EN:  cfg_q.proto_en  <= cfg_wdata[0];
				REG_PROTO_VAL: cfg_q.proto_val <= cfg_wdata[PROTO_W-1:0];
				REG_EVENT_EN:  cfg_q.event_en  <= cfg_wdata[0];
				REG_EVENT_VAL: cfg_q.event_val <= cfg_wdata[EVT_W-1:0];
				default: ;
			endcase
		end
	end

	nrpf_ctrl #(
		.DEPTH (LIST_DEPTH),
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.wr      (wr),
		.wr_idx  (wr_idx),
		.rd_addr (rd_addr),
		.rd      (rd)
	);

	nrpf_rule_mem #(
		.DEPTH (LIST_DEPTH),
		.IDX_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr      (wr),
		.wr_idx  (wr_idx),
		.rd_addr (rd_addr),
		.rd      (rd)
	);

endmodule
`default_nettype wire
